### rtl/assert_macros.svh
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SJQ_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// expression must never be true outside reset
`define SJQ_ASSERT_NEVER(name, clk, rstn, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

### rtl/sjq_pkg.sv
// types, codes and helpers of the sorted job queue
`default_nettype none

package sjq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W       = 16;

    // operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_RESORT = 2'd2;

    // ordering modes
    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [7:0]  job_id;
        logic [15:0] cpu_time;
        logic [7:0]  job_priority;
    } job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  job_id;
        logic [15:0] cpu_time;
        logic [7:0]  job_priority;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_job_id;
        logic [15:0]      out_cpu_time;
        logic [7:0]       out_priority;
        logic [CNT_W-1:0] fill;
    } out_item_t;

    // what every cell does with its entry
    typedef enum logic [1:0] {
        MOVE_HOLD,
        MOVE_INSERT,
        MOVE_LEFT,
        MOVE_SORT
    } move_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_POP,
        S_REPLY,
        S_SORT_EVAL,
        S_SORT_MOVE
    } state_t;

    // broadcast from the controller to the row of cells
    typedef struct packed {
        logic             eval;
        logic             ordered;
        logic             cpu_key;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        move_t            move;
        job_t             new_entry;
    } cell_ctrl_t;

    function automatic logic [KEY_W-1:0] job_key(job_t j, logic cpu_key);
        logic [KEY_W-1:0] k;
        if (cpu_key) begin
            k = j.cpu_time;
        end else begin
            k = {{(KEY_W - 8){1'b0}}, j.job_priority};
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/sjq_cell.sv
// one slot of the queue: holds a job, flags the insert point, shifts
`default_nettype none

module sjq_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sjq_pkg::cell_ctrl_t        ctrl,
    input  logic [sjq_pkg::KEY_W-1:0]  left_key,
    input  sjq_pkg::job_t              left_entry,
    input  sjq_pkg::job_t              right_entry,
    input  logic                       clr_before,
    input  logic                       clr_at,
    input  logic                       clr_next,
    output sjq_pkg::job_t              entry,
    output logic [sjq_pkg::KEY_W-1:0]  key,
    output logic                       hit
);
    import sjq_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_INDEX);

    job_t entry_reg;
    job_t entry_next;
    logic hit_reg;
    logic hit_next;
    logic head_hit;
    logic mid_hit;
    logic tail_hit;

    assign key   = job_key(entry_reg, ctrl.cpu_key);
    assign entry = entry_reg;
    assign hit   = hit_reg;

    // insert point test within the sorted region lo..hi-1, or at hi after it (only hi when unordered)
    always_comb begin
        head_hit = (IDX == ctrl.lo) && (ctrl.lo < ctrl.hi) && (key > ctrl.key);
        mid_hit  = (IDX > ctrl.lo) && (IDX < ctrl.hi) &&
                   (left_key <= ctrl.key) && (key >= ctrl.key);
        tail_hit = (IDX == ctrl.hi);
        if (ctrl.ordered) begin
            hit_next = head_hit || mid_hit || tail_hit;
        end else begin
            hit_next = tail_hit;
        end
    end

    // entry movement
    always_comb begin
        entry_next = entry_reg;
        case (ctrl.move)
            MOVE_INSERT: begin
                if (!clr_before) begin
                    entry_next = left_entry;
                end else if (!clr_at) begin
                    entry_next = ctrl.new_entry;
                end
            end
            MOVE_LEFT: begin
                entry_next = right_entry;
            end
            MOVE_SORT: begin
                if (clr_next) begin
                    entry_next = right_entry;
                end else if (clr_at) begin
                    entry_next = ctrl.new_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctrl.eval) begin
            hit_reg <= hit_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sorted_job_queue.sv
// sorted job queue top level: controller, row of cells, result register
//
//   channel   ports               direction  carries
//   s_        s_valid/s_ready     in         in_item_t (insert, pop, resort)
//   m_        m_valid/m_ready     out        out_item_t (status, job, fill)
//   cfg_      cfg_wr_en           in         order_mode, no wait
//
// insert: the accept cycle evaluates the insert point in every cell and the insert
// state shifts the row; pop shifts it left in the pop state; rejected or ignored
// operations only reply. resort moves each job from the head into the sorted
// tail in an evaluate state and a shift state.
// reset clears fill and control only; slots need no clearing pass.
// a stalled result register holds the controller in its finishing state.
`default_nettype none

module sorted_job_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sjq_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sjq_pkg::out_item_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);
    import sjq_pkg::*;

`include "assert_macros.svh"

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    state_t           state_reg, state_next;
    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [1:0]       status_reg, status_next;
    job_t             new_reg, new_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg;

    cell_ctrl_t       ctrl;
    logic             res_load;
    out_item_t        res_data;
    logic             out_free;
    logic             ordered;
    job_t             in_job;

    job_t             entries [QUEUE_DEPTH];
    logic [KEY_W-1:0] keys    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic [QUEUE_DEPTH-1:0] clr_at_vec;

    assign out_free = !m_valid_reg || m_ready;
    assign ordered  = (mode_reg == MODE_SJF) || (mode_reg == MODE_PRIO);
    assign in_job   = '{job_id: s_data.job_id, cpu_time: s_data.cpu_time,
                        job_priority: s_data.job_priority};

    // row of cells
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            logic [KEY_W-1:0] left_key_w;
            job_t             left_entry_w;
            job_t             right_entry_w;
            logic             clr_before_w;
            logic             clr_next_w;

            // no insert point at or before this cell
            assign clr_at_vec[i] = ~|hit_vec[i:0];

            if (i == 0) begin : g_first
                assign left_key_w   = '0;
                assign left_entry_w = entries[0];
                assign clr_before_w = 1'b1;
            end else begin : g_inner_left
                assign left_key_w   = keys[i-1];
                assign left_entry_w = entries[i-1];
                assign clr_before_w = clr_at_vec[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_last
                assign right_entry_w = entries[i];
                assign clr_next_w    = 1'b0;
            end else begin : g_inner_right
                assign right_entry_w = entries[i+1];
                assign clr_next_w    = clr_at_vec[i+1];
            end

            sjq_cell #(
                .CELL_INDEX (i)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_key    (left_key_w),
                .left_entry  (left_entry_w),
                .right_entry (right_entry_w),
                .clr_before  (clr_before_w),
                .clr_at      (clr_at_vec[i]),
                .clr_next    (clr_next_w),
                .entry       (entries[i]),
                .key         (keys[i]),
                .hit         (hit_vec[i])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_data.kind)
                        KIND_INSERT: begin
                            state_next = (count_reg < DEPTH_CNT) ? S_INSERT : S_REPLY;
                        end
                        KIND_POP: begin
                            state_next = (count_reg != '0) ? S_POP : S_REPLY;
                        end
                        KIND_RESORT: begin
                            state_next = (ordered && count_reg != '0) ? S_SORT_EVAL
                                                                      : S_REPLY;
                        end
                        default: begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_INSERT, S_POP, S_REPLY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SORT_EVAL: begin
                state_next = S_SORT_MOVE;
            end
            S_SORT_MOVE: begin
                state_next = (lo_reg == ONE_CNT) ? S_REPLY : S_SORT_EVAL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // controller outputs and datapath updates
    always_comb begin
        s_ready        = 1'b0;
        res_load       = 1'b0;
        res_data       = '0;
        res_data.fill  = count_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        status_next    = status_reg;
        new_next       = new_reg;
        ctrl.eval      = 1'b0;
        ctrl.ordered   = ordered;
        ctrl.cpu_key   = (mode_reg == MODE_SJF);
        ctrl.key       = keys[0];
        ctrl.lo        = lo_reg;
        ctrl.hi        = count_reg;
        ctrl.move      = MOVE_HOLD;
        ctrl.new_entry = entries[0];
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                ctrl.key = job_key(in_job, mode_reg == MODE_SJF);
                ctrl.lo  = '0;
                if (s_valid) begin
                    new_next    = in_job;
                    lo_next     = count_reg;
                    status_next = STATUS_OK;
                    if (s_data.kind == KIND_INSERT) begin
                        if (count_reg < DEPTH_CNT) begin
                            ctrl.eval = 1'b1;
                        end else begin
                            status_next = STATUS_FULL;
                        end
                    end else if (s_data.kind == KIND_POP && count_reg == '0) begin
                        status_next = STATUS_EMPTY;
                    end
                end
            end
            S_INSERT: begin
                ctrl.new_entry = new_reg;
                if (out_free) begin
                    ctrl.move     = MOVE_INSERT;
                    count_next    = count_reg + ONE_CNT;
                    res_load      = 1'b1;
                    res_data.fill = count_reg + ONE_CNT;
                end
            end
            S_POP: begin
                if (out_free) begin
                    ctrl.move             = MOVE_LEFT;
                    count_next            = count_reg - ONE_CNT;
                    res_load              = 1'b1;
                    res_data.status       = STATUS_OK;
                    res_data.out_job_id   = entries[0].job_id;
                    res_data.out_cpu_time = entries[0].cpu_time;
                    res_data.out_priority = entries[0].job_priority;
                    res_data.fill         = count_reg - ONE_CNT;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    res_load        = 1'b1;
                    res_data.status = status_reg;
                end
            end
            S_SORT_EVAL: begin
                ctrl.eval = 1'b1;
            end
            S_SORT_MOVE: begin
                ctrl.move = MOVE_SORT;
                lo_next   = lo_reg - ONE_CNT;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result register
    always_comb begin
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res_data;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_FCFS;
            count_reg   <= '0;
            lo_reg      <= '0;
            status_reg  <= STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lo_reg      <= lo_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // job latched from every accepted transfer, used by insert
    always_ff @(posedge aclk) begin
        new_reg <= new_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SJQ_ASSERT_NEVER(a_fill_bound, aclk, aresetn, count_reg > DEPTH_CNT, "fill above depth")
    `SJQ_ASSERT(a_insert_point, aclk, aresetn, (state_reg == S_INSERT) |-> (hit_vec != '0), "insert without an insert point")
    `SJQ_ASSERT(a_result_free, aclk, aresetn, res_load |-> (!m_valid_reg || m_ready), "result overwrites a pending transfer")
    `SJQ_ASSERT(a_pop_count, aclk, aresetn, (state_reg == S_POP && res_load) |=> (count_reg == $past(count_reg) - ONE_CNT), "pop did not lower fill")

endmodule

`default_nettype wire
